// ----- src/proportional_motor_position_drive_unit_assert.svh -----
// Assertion macros used by the checker of the position drive unit.
// Expects i_clk and i_rst_n to be visible where a macro is used.
`ifndef PROPORTIONAL_MOTOR_POSITION_DRIVE_UNIT_ASSERT_SVH
`define PROPORTIONAL_MOTOR_POSITION_DRIVE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held.
`define PMPD_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pmpd check failed: same-cycle implication");

// Next-cycle implication, disabled while reset is held.
`define PMPD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pmpd check failed: next-cycle implication");

`endif

// ----- src/pmpd_pkg.sv -----
// Package for the proportional motor position drive unit.
// Holds field widths, register indexes, reset values and divider constants.
package pmpd_pkg;

    localparam int SAMPLE_W = 10;
    localparam int SUM_W    = 12;
    localparam int DIFF_W   = 12;
    localparam int GAIN_W   = 16;
    localparam int BYTE_W   = 8;
    localparam int PERIOD_W = 20;
    localparam int MAG_W    = 10;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 20;

    localparam int SAMPLES = 3;

    // Exact floor(v / SAMPLES) for v below 4096 as (v * RECIP_MUL) >> RECIP_SHIFT.
    localparam int RECIP_MUL   = 2731;
    localparam int RECIP_SHIFT = 13;

    localparam int PWM_SCALE = 255;
    localparam logic [MAG_W-1:0] MAG_MAX = '1;

    localparam logic [GAIN_W-1:0]   RST_GAIN     = 16'd6554;
    localparam logic [BYTE_W-1:0]   RST_DEAD     = 8'd3;
    localparam logic [BYTE_W-1:0]   RST_MIN_PWM  = 8'd160;
    localparam logic [PERIOD_W-1:0] RST_RUN_PER  = 20'd40000;
    localparam logic [PERIOD_W-1:0] RST_STOP_PER = 20'd45000;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN     = 3'd0,
        CFG_DEAD     = 3'd1,
        CFG_MIN_PWM  = 3'd2,
        CFG_RUN_PER  = 3'd3,
        CFG_STOP_PER = 3'd4
    } t_cfg_index;

endpackage

// ----- src/proportional_motor_position_drive_unit.sv -----
// Top level of the proportional motor position drive unit.
// Six-stage pipeline from samples to PWM settings; uses pmpd_pkg.
//
//   channel | direction | handshake              | payload
//   in      | into unit | i_in_valid / o_in_stall | sample_a/b/c, target_position
//   out     | from unit | o_out_valid / i_out_stall | direction, moving, period, duty, magnitude
//   cfg     | into unit | i_cfg_wr_en             | i_cfg_index, i_cfg_wdata
//
// One beat is accepted every cycle while the output is not stalled; a result passes through
// the stage registers and the output register before it is offered.
// The gain multiply, the divide by three and the period multiply each own a stage.
// A stalled output beat freezes every stage, so the input stalls in the same cycle.
// Reset is synchronous and active low; it clears the valid bits and loads the configuration registers.
module proportional_motor_position_drive_unit
    import pmpd_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [SAMPLE_W-1:0]   i_sample_a,
    input  logic [SAMPLE_W-1:0]   i_sample_b,
    input  logic [SAMPLE_W-1:0]   i_sample_c,
    input  logic [SAMPLE_W-1:0]   i_target_position,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic                  o_direction,
    output logic                  o_moving,
    output logic [PERIOD_W-1:0]   o_period_ns,
    output logic [PERIOD_W-1:0]   o_duty_ns,
    output logic [MAG_W-1:0]      o_drive_magnitude,
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    logic                gain_wr;
    logic [GAIN_W-1:0]   r_gain;
    logic [BYTE_W-1:0]   r_dead;
    logic [BYTE_W-1:0]   r_min_pwm;
    logic [PERIOD_W-1:0] r_run_per;
    logic [PERIOD_W-1:0] r_stop_per;

    logic en;

    logic [SUM_W-1:0]    sum;
    logic [SUM_W:0]      sum_inc;
    logic [SAMPLE_W-1:0] mapped;
    logic [SUM_W-1:0]    scaled;
    logic [DIFF_W-1:0]   n1_diff;
    logic                n1_pos;

    logic                r1_valid;
    logic [DIFF_W-1:0]   r1_diff;
    logic                r1_pos;

    logic [DIFF_W+GAIN_W-1:0] prod;

    logic                r2_valid;
    logic [DIFF_W-1:0]   r2_quot;
    logic                r2_pos;

    logic [2*DIFF_W-1:0] recip;
    logic [DIFF_W-RECIP_SHIFT+DIFF_W-1:0] div3;
    logic [MAG_W-1:0]    n3_mag;
    logic                n3_moving;
    logic [MAG_W:0]      n3_level;

    logic                r3_valid;
    logic [MAG_W-1:0]    r3_mag;
    logic                r3_pos;
    logic                r3_moving;
    logic [MAG_W:0]      r3_level;

    logic [PERIOD_W+BYTE_W-1:0] scaled_duty;

    logic                r4_valid;
    logic [MAG_W-1:0]    r4_mag;
    logic                r4_pos;
    logic                r4_moving;
    logic                r4_sat;
    logic [PERIOD_W+BYTE_W-1:0] r4_prod;

    logic [PERIOD_W:0]   dz;
    logic [PERIOD_W-BYTE_W:0] dw;
    logic [BYTE_W:0]     dv;

    logic                r5_valid;
    logic [MAG_W-1:0]    r5_mag;
    logic                r5_pos;
    logic                r5_moving;
    logic                r5_sat;
    logic [PERIOD_W-1:0] r5_y;
    logic [PERIOD_W-BYTE_W:0] r5_z1;
    logic [PERIOD_W-2*BYTE_W:0] r5_w1;
    logic                r5_vge;

    logic [PERIOD_W-1:0] quot255;

    logic                r_out_valid;
    logic                r_direction;
    logic                r_moving;
    logic [PERIOD_W-1:0] r_period;
    logic [PERIOD_W-1:0] r_duty;
    logic [MAG_W-1:0]    r_mag;

    assign en         = !(r_out_valid && i_out_stall);
    assign o_in_stall = !en;
    assign gain_wr    = i_cfg_wr_en && (i_cfg_index == CFG_GAIN);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gain     <= RST_GAIN;
            r_dead     <= RST_DEAD;
            r_min_pwm  <= RST_MIN_PWM;
            r_run_per  <= RST_RUN_PER;
            r_stop_per <= RST_STOP_PER;
        end else if (gain_wr) begin
            r_gain <= i_cfg_wdata[GAIN_W-1:0];
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_DEAD:     r_dead     <= i_cfg_wdata[BYTE_W-1:0];
                CFG_MIN_PWM:  r_min_pwm  <= i_cfg_wdata[BYTE_W-1:0];
                CFG_RUN_PER:  r_run_per  <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_STOP_PER: r_stop_per <= i_cfg_wdata[PERIOD_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage 1: sum, map to ten bits, signed error against the scaled target.
    always_comb begin
        sum     = SUM_W'(i_sample_a) + SUM_W'(i_sample_b) + SUM_W'(i_sample_c);
        sum_inc = (SUM_W+1)'(sum) + (SUM_W+1)'(1);
        if (sum < SUM_W'(4)) begin
            mapped = '0;
        end else begin
            mapped = sum_inc[SAMPLE_W+1:2] - SAMPLE_W'(1);
        end
        scaled = SUM_W'(SAMPLES) * SUM_W'(i_target_position);
        if (scaled >= SUM_W'(mapped)) begin
            n1_diff = scaled - SUM_W'(mapped);
            n1_pos  = (n1_diff != '0);
        end else begin
            n1_diff = SUM_W'(mapped) - scaled;
            n1_pos  = 1'b0;
        end
    end

    // Stage 2: gain multiply, keep the integer part.
    assign prod = (DIFF_W+GAIN_W)'(r1_diff) * (DIFF_W+GAIN_W)'(r_gain);

    // Stage 3: divide by the sample count, dead band and duty level.
    always_comb begin
        recip  = (2*DIFF_W)'(r2_quot) * (2*DIFF_W)'(RECIP_MUL);
        div3   = recip[2*DIFF_W-1:RECIP_SHIFT];
        if (div3 > (DIFF_W-RECIP_SHIFT+DIFF_W)'(MAG_MAX)) begin
            n3_mag = MAG_MAX;
        end else begin
            n3_mag = div3[MAG_W-1:0];
        end
        n3_moving = !(n3_mag < MAG_W'(r_dead));
        n3_level  = (MAG_W+1)'(n3_mag) + (MAG_W+1)'(r_min_pwm);
    end

    // Stage 4: period times level; a level of full scale or more saturates.
    assign scaled_duty = (PERIOD_W+BYTE_W)'(r_run_per) * (PERIOD_W+BYTE_W)'(r3_level[BYTE_W-1:0]);

    // Stage 5: divide by 255 through base-256 digit folding.
    always_comb begin
        dz = (PERIOD_W+1)'(r4_prod[PERIOD_W+BYTE_W-1:BYTE_W])
           + (PERIOD_W+1)'(r4_prod[BYTE_W-1:0]);
        dw = (PERIOD_W-BYTE_W+1)'(dz[PERIOD_W:BYTE_W])
           + (PERIOD_W-BYTE_W+1)'(dz[BYTE_W-1:0]);
        dv = (BYTE_W+1)'(dw[PERIOD_W-BYTE_W:BYTE_W]) + (BYTE_W+1)'(dw[BYTE_W-1:0]);
    end

    // Stage 6: sum the folded digits and form the result.
    assign quot255 = r5_y + PERIOD_W'(r5_z1) + PERIOD_W'(r5_w1) + PERIOD_W'(r5_vge);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid    <= 1'b0;
            r2_valid    <= 1'b0;
            r3_valid    <= 1'b0;
            r4_valid    <= 1'b0;
            r5_valid    <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r1_valid    <= i_in_valid;
            r2_valid    <= r1_valid;
            r3_valid    <= r2_valid;
            r4_valid    <= r3_valid;
            r5_valid    <= r4_valid;
            r_out_valid <= r5_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r1_diff   <= n1_diff;
            r1_pos    <= n1_pos;

            r2_quot   <= prod[DIFF_W+GAIN_W-1:GAIN_W];
            r2_pos    <= r1_pos;

            r3_mag    <= n3_mag;
            r3_pos    <= r2_pos && (n3_mag != '0);
            r3_moving <= n3_moving;
            r3_level  <= n3_level;

            r4_mag    <= r3_mag;
            r4_pos    <= r3_pos;
            r4_moving <= r3_moving;
            r4_sat    <= (r3_level >= (MAG_W+1)'(PWM_SCALE));
            r4_prod   <= scaled_duty;

            r5_mag    <= r4_mag;
            r5_pos    <= r4_pos;
            r5_moving <= r4_moving;
            r5_sat    <= r4_sat;
            r5_y      <= r4_prod[PERIOD_W+BYTE_W-1:BYTE_W];
            r5_z1     <= dz[PERIOD_W:BYTE_W];
            r5_w1     <= dw[PERIOD_W-BYTE_W:BYTE_W];
            r5_vge    <= (dv >= (BYTE_W+1)'(PWM_SCALE));

            r_mag     <= r5_mag;
            r_moving  <= r5_moving;
            if (r5_moving) begin
                r_direction <= !r5_pos;
                r_period    <= r_run_per;
                r_duty      <= r5_sat ? r_run_per : quot255;
            end else begin
                r_direction <= 1'b1;
                r_period    <= r_stop_per;
                r_duty      <= '0;
            end
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_direction       = r_direction;
    assign o_moving          = r_moving;
    assign o_period_ns       = r_period;
    assign o_duty_ns         = r_duty;
    assign o_drive_magnitude = r_mag;

endmodule

// ----- src/pmpd_checker.sv -----
// Port-level checker for the proportional motor position drive unit.
// Uses pmpd_pkg and the assertion macros; bound to the top level below.
`include "proportional_motor_position_drive_unit_assert.svh"

module pmpd_checker
    import pmpd_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_stall,
    input logic                o_out_valid,
    input logic                i_out_stall,
    input logic                o_direction,
    input logic                o_moving,
    input logic [PERIOD_W-1:0] o_period_ns,
    input logic [PERIOD_W-1:0] o_duty_ns,
    input logic [MAG_W-1:0]    o_drive_magnitude
);

    logic [2*PERIOD_W+MAG_W+1:0] out_beat;

    assign out_beat = {o_direction, o_moving, o_period_ns, o_duty_ns, o_drive_magnitude};

    // A stalled output beat stays and keeps its payload.
    `PMPD_ASSERT_NEXT(a_out_hold, o_out_valid && i_out_stall, o_out_valid && $stable(out_beat))

    // A stopped result drives no pulse and holds the backward level.
    `PMPD_ASSERT_NOW(a_stop_form, o_out_valid && !o_moving, o_direction && (o_duty_ns == '0))

    // While moving, the pulse never exceeds the period.
    `PMPD_ASSERT_NOW(a_duty_bound, o_out_valid && o_moving, o_duty_ns <= o_period_ns)

    // The input side stalls only behind a waiting, stalled output beat.
    `PMPD_ASSERT_NOW(a_in_stall_cause, o_in_stall, o_out_valid && i_out_stall)

endmodule

bind proportional_motor_position_drive_unit pmpd_checker u_pmpd_checker (.*);
